@@ rtl/idct_pkg.sv @@
// ----------------------------------------------------------------------------
// idct_pkg
// Shared types and constants of the direct-form 8x8 inverse DCT.
// ----------------------------------------------------------------------------
package idct_pkg;

  // Accumulator width of the multiply-accumulate path.
  localparam int ACC_WIDTH = 48;
  // Width of one reconstructed sample.
  localparam int SAMPLE_WIDTH = 16;
  // Largest magnitudes that fit a signed sample.
  localparam int SAT_POS_MAG = 32767;
  localparam int SAT_NEG_MAG = 32768;
  // Last index of an 8x8 block and of one 8-entry axis.
  localparam logic [5:0] LAST_INDEX = 6'd63;
  localparam logic [2:0] LAST_AXIS  = 3'd7;

  // cos(k*pi/16) for k = 0..7 in Q30; entry 0 holds 1/sqrt(2) for C(0).
  localparam logic [29:0] COS_Q30 [8] = '{
    30'd759250125, 30'd1053110176, 30'd992008094, 30'd892783698,
    30'd759250125, 30'd596538995,  30'd410903207, 30'd209476638
  };

  // Controller states.
  typedef enum logic [1:0] {
    ST_LOAD,
    ST_RUN,
    ST_DRAIN
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic       load;
    logic [5:0] load_addr;
    logic       issue;
    logic [5:0] term;
    logic [5:0] samp;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic out_last;
  } stat_t;

endpackage

@@ rtl/idct_ctrl.sv @@
// ----------------------------------------------------------------------------
// idct_ctrl
// Controller: counts coefficients in, then steps the shared MAC through all
// 64 terms of each of the 64 samples and waits for the pipeline to drain.
// ----------------------------------------------------------------------------
module idct_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  output logic          busy,
  output idct_pkg::cmd_t cmd,
  input  idct_pkg::stat_t stat
);
  import idct_pkg::*;

  state_t     state, state_next;
  logic [5:0] load_count, load_count_next;
  logic [5:0] term, term_next;
  logic [5:0] samp, samp_next;

  // State and counter registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_LOAD;
      load_count <= '0;
      term       <= '0;
      samp       <= '0;
    end else begin
      state      <= state_next;
      load_count <= load_count_next;
      term       <= term_next;
      samp       <= samp_next;
    end
  end

  // Next state and commands.
  always_comb begin
    state_next      = state;
    load_count_next = load_count;
    term_next       = term;
    samp_next       = samp;
    busy            = 1'b1;
    cmd.load        = 1'b0;
    cmd.load_addr   = load_count;
    cmd.issue       = 1'b0;
    cmd.term        = term;
    cmd.samp        = samp;
    case (state)
      ST_LOAD: begin
        busy = 1'b0;
        if (start) begin
          cmd.load        = 1'b1;
          load_count_next = load_count + 6'd1;
          if (load_count == LAST_INDEX) begin
            term_next  = '0;
            samp_next  = '0;
            state_next = ST_RUN;
          end
        end
      end
      ST_RUN: begin
        cmd.issue = 1'b1;
        term_next = term + 6'd1;
        if (term == LAST_INDEX) begin
          samp_next = samp + 6'd1;
          if (samp == LAST_INDEX) begin
            state_next = ST_DRAIN;
          end
        end
      end
      ST_DRAIN: begin
        if (stat.out_last) begin
          state_next = ST_LOAD;
        end
      end
      default: begin
        state_next = ST_LOAD;
      end
    endcase
  end

endmodule

@@ rtl/idct_dp.sv @@
// ----------------------------------------------------------------------------
// idct_dp
// Datapath: coefficient memory, basis table, one pipelined multiply-
// accumulate unit and the scaling and saturation of each finished sample.
// ----------------------------------------------------------------------------
module idct_dp #(
  parameter int COEF_WIDTH      = 12,
  parameter int TABLE_FRAC_BITS = 14
) (
  input  logic                   clk,
  input  logic                   rst,
  input  idct_pkg::cmd_t         cmd,
  input  logic [COEF_WIDTH-1:0]  coef_value,
  output idct_pkg::stat_t        stat,
  output logic                   strobe,
  output logic [idct_pkg::SAMPLE_WIDTH-1:0] sample_value,
  output logic [2:0]             sample_row,
  output logic [2:0]             sample_col,
  output logic                   block_last
);
  import idct_pkg::*;

  localparam int TW  = TABLE_FRAC_BITS + 2;
  localparam int PW  = 2 * TW + COEF_WIDTH;
  localparam int RSH = 30 - TABLE_FRAC_BITS;
  localparam int OSH = 2 * TABLE_FRAC_BITS + 2;

  // One basis entry T[x][u] in Q1.TABLE_FRAC_BITS, rounded on the magnitude.
  function automatic logic signed [TW-1:0] tab(input logic [2:0] x, input logic [2:0] u);
    logic [6:0]  prod;
    logic [4:0]  k;
    logic        neg;
    logic [30:0] m;
    prod = {3'b000, x, 1'b1} * {4'b0000, u};
    k    = prod[4:0];
    neg  = 1'b0;
    if (k > 5'd16) begin
      k = 5'd0 - k;
    end
    if (k > 5'd8) begin
      neg = 1'b1;
      k   = 5'd16 - k;
    end
    m = ({1'b0, COS_Q30[k[2:0]]} + (31'd1 << (RSH - 1))) >> RSH;
    return neg ? -TW'(m) : TW'(m);
  endfunction

  logic signed [COEF_WIDTH-1:0] mem [64];
  logic signed [COEF_WIDTH-1:0] coef_rd;
  logic signed [2*TW-1:0]       tt;
  logic signed [TW-1:0]         tx, ty;
  logic                         a_valid, a_first, a_last;
  logic [5:0]                   a_samp;
  logic signed [PW-1:0]         prod;
  logic                         b_valid, b_first, b_last;
  logic [5:0]                   b_samp;
  logic signed [ACC_WIDTH-1:0]  acc;
  logic                         c_fin;
  logic [5:0]                   c_samp;
  logic [ACC_WIDTH:0]           mag;
  logic [ACC_WIDTH:0]           q;
  logic [SAMPLE_WIDTH-1:0]      sat;

  // Coefficient memory: one write port for loading, one registered read port.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mem[cmd.load_addr] <= coef_value;
    end
    coef_rd <= mem[cmd.term];
  end

  // Basis lookup for the current term.
  always_comb begin
    tx = tab(cmd.samp[5:3], cmd.term[5:3]);
    ty = tab(cmd.samp[2:0], cmd.term[2:0]);
  end

  // Stage A: product of the two basis entries, exact.
  always_ff @(posedge clk) begin
    tt     <= (2*TW)'(tx) * (2*TW)'(ty);
    a_samp <= cmd.samp;
    a_first <= (cmd.term == '0);
    a_last  <= (cmd.term == LAST_INDEX);
  end

  // Stage B: weight the coefficient.
  always_ff @(posedge clk) begin
    prod    <= PW'(tt) * PW'(coef_rd);
    b_samp  <= a_samp;
    b_first <= a_first;
    b_last  <= a_last;
  end

  // Stage C: accumulate, restarting on the first term of a sample.
  always_ff @(posedge clk) begin
    if (b_valid) begin
      acc <= (b_first ? '0 : acc) + ACC_WIDTH'(prod);
    end
    c_samp <= b_samp;
  end

  // Valid flags of the pipeline.
  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
      b_valid <= 1'b0;
      c_fin   <= 1'b0;
      strobe  <= 1'b0;
    end else begin
      a_valid <= cmd.issue;
      b_valid <= a_valid;
      c_fin   <= b_valid && b_last;
      strobe  <= c_fin;
    end
  end

  // Scale by the fixed shift, truncating toward zero, then saturate.
  always_comb begin
    mag = acc[ACC_WIDTH-1] ? -{acc[ACC_WIDTH-1], acc} : {acc[ACC_WIDTH-1], acc};
    q   = mag >> OSH;
    if (!acc[ACC_WIDTH-1]) begin
      sat = (q > (ACC_WIDTH+1)'(SAT_POS_MAG)) ? SAMPLE_WIDTH'(SAT_POS_MAG)
                                                : q[SAMPLE_WIDTH-1:0];
    end else begin
      sat = (q > (ACC_WIDTH+1)'(SAT_NEG_MAG)) ? SAMPLE_WIDTH'(SAT_NEG_MAG)
                                                : ~q[SAMPLE_WIDTH-1:0] + 1'b1;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (c_fin) begin
      sample_value <= sat;
      sample_row   <= c_samp[5:3];
      sample_col   <= c_samp[2:0];
    end
  end

  assign block_last    = strobe && (sample_row == LAST_AXIS) && (sample_col == LAST_AXIS);
  assign stat.out_last = block_last;

endmodule

@@ rtl/idct_8x8_direct.sv @@
// ----------------------------------------------------------------------------
// idct_8x8_direct
// Direct-form 8x8 two-dimensional inverse DCT with one shared MAC.
// ----------------------------------------------------------------------------
// The block takes one coefficient per cycle while busy is low and start is high,
// 64 of them in row-major order. After the sixty-fourth, busy stays high while
// a single multiply-accumulate unit works through 64 terms for each of the 64
// samples, and then while its pipeline drains. The samples leave in row-major
// order, each marked by strobe for exactly one cycle; the receiver cannot
// stall them and must take each one as it appears. Busy falls in the cycle
// after the last sample, so the single shared MAC takes no coefficients of a
// new block until the last sample of the previous block has left.
module idct_8x8_direct #(
  parameter int COEF_WIDTH      = 12,
  parameter int TABLE_FRAC_BITS = 14
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  output logic                  busy,
  input  logic [COEF_WIDTH-1:0] coef_value,
  output logic                  strobe,
  output logic [idct_pkg::SAMPLE_WIDTH-1:0] sample_value,
  output logic [2:0]            sample_row,
  output logic [2:0]            sample_col,
  output logic                  block_last
);
  import idct_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  // Sequencing of loading and computation.
  idct_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .cmd   (cmd),
    .stat  (stat)
  );

  // Storage and arithmetic.
  idct_dp #(
    .COEF_WIDTH      (COEF_WIDTH),
    .TABLE_FRAC_BITS (TABLE_FRAC_BITS)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .coef_value   (coef_value),
    .stat         (stat),
    .strobe       (strobe),
    .sample_value (sample_value),
    .sample_row   (sample_row),
    .sample_col   (sample_col),
    .block_last   (block_last)
  );

endmodule

@@ rtl/idct_chk.sv @@
// ----------------------------------------------------------------------------
// idct_chk
// Port-level checks of the inverse DCT, bound to the top level.
// ----------------------------------------------------------------------------
module idct_chk (
  input logic        clk,
  input logic        rst,
  input logic        busy,
  input logic        strobe,
  input logic [15:0] sample_value,
  input logic [2:0]  sample_row,
  input logic [2:0]  sample_col,
  input logic        block_last
);

  // The block-end mark only comes with the final sample of a block.
  a_last_pos: assert property (@(posedge clk) disable iff (rst)
    block_last |-> strobe && sample_row == 3'd7 && sample_col == 3'd7)
    else $error("block_last without the final sample");

  // No sample is delivered while new coefficients can be taken.
  a_busy_out: assert property (@(posedge clk) disable iff (rst)
    strobe |-> busy)
    else $error("sample delivered while not busy");

  // Samples follow in row-major order.
  a_order: assert property (@(posedge clk) disable iff (rst)
    strobe && !block_last |-> ##64 strobe &&
      {sample_row, sample_col} == $past({sample_row, sample_col}, 64) + 6'd1)
    else $error("sample order broken");

  // The block is ready for new coefficients right after its last sample.
  a_release: assert property (@(posedge clk) disable iff (rst)
    block_last |=> !busy)
    else $error("busy held after the last sample");

  // A delivered sample carries no unknown bits.
  a_known: assert property (@(posedge clk) disable iff (rst)
    strobe |-> !$isunknown({sample_value, sample_row, sample_col}))
    else $error("sample with unknown bits");

endmodule

bind idct_8x8_direct idct_chk u_idct_chk (.*);
